### rtl/assert_macros.svh
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLDS(label, clk, rst, expr)
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/mqw_pkg.sv
// Request and status codes and the result record of the message queue.
package mqw_pkg;

  localparam int CAP_W  = 5;
  localparam int TASK_W = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [2:0] REQ_POST_BACK  = 3'd0;
  localparam logic [2:0] REQ_POST_FRONT = 3'd1;
  localparam logic [2:0] REQ_ACCEPT     = 3'd2;
  localparam logic [2:0] REQ_PEND       = 3'd3;
  localparam logic [2:0] REQ_TIMEOUT    = 3'd4;
  localparam logic [2:0] REQ_FLUSH      = 3'd5;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_WAITING = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  typedef struct packed {
    logic [2:0]        status;
    logic              took;       // msg_out comes from the store read
    logic              wake_valid;
    logic [TASK_W-1:0] wake_task;
    logic [CAP_W-1:0]  msg_count;
    logic [CAP_W-1:0]  slot_count;
  } mqw_res_t;

endpackage

### rtl/message_queue_with_waiters_core.sv
// Message queue with waiter bitmap: handshake, storage and control.
//
// Requests enter on in_valid/in_stall with req_type, msg_in and task_id;
// each request gives exactly one response on out_valid/out_stall.
// A request is taken when valid is high and stall is low.
// The response is registered at the accept edge and msg_out comes from the
// synchronous read of the message store at that edge.
// Throughput is one request per cycle while no response is held by out_stall;
// the single ring access per request and the response register set it.
// in_stall is high only while a response waits and out_stall holds it; the
// response and the store read data are held unchanged until taken.
// Reset clears the ring pointers, count and waiter mask and sets capacity
// to 16. Message store contents are not cleared; only posted slots are read.
// A capacity write (cfg_wr_en) empties the queue and clears all waiters;
// write it only while no response is outstanding.
`include "assert_macros.svh"
module message_queue_with_waiters_core
  import mqw_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int MAX_TASKS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        req_type,
  input  logic [7:0]        msg_in,
  input  logic [TASK_W-1:0] task_id,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        status,
  output logic [7:0]        msg_out,
  output logic              wake_valid,
  output logic [TASK_W-1:0] wake_task,
  output logic [CAP_W-1:0]  msg_count,
  output logic [CAP_W-1:0]  slot_count,
  input  logic              cfg_wr_en,
  input  logic [CAP_W-1:0]  cfg_wr_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          accept;
  logic          mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_wr_idx, mem_rd_idx;
  logic [7:0]    mem_wr_data, rd_data;
  mqw_res_t      res;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  mqw_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_TASKS (MAX_TASKS),
    .AW        (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .req_type    (req_type),
    .msg_in      (msg_in),
    .task_id     (task_id),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_idx  (mem_wr_idx),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_idx  (mem_rd_idx),
    .res         (res)
  );

  mqw_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_idx  (mem_wr_idx),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_idx  (mem_rd_idx),
    .rd_data (rd_data)
  );

  assign status     = res.status;
  assign msg_out    = res.took ? rd_data : 8'd0;
  assign wake_valid = res.wake_valid;
  assign wake_task  = res.wake_task;
  assign msg_count  = res.msg_count;
  assign slot_count = res.slot_count;

  `ASSERT_NEXT(a_accept_gives_resp, clk, rst, accept, out_valid)
  `ASSERT_IMPL(a_count_in_range, clk, rst, out_valid, msg_count <= slot_count)
  `ASSERT_IMPL(a_wake_first_msg, clk, rst, out_valid && wake_valid,
               status == ST_OK && msg_count == CAP_W'(1))
  `ASSERT_IMPL(a_wait_when_empty, clk, rst, out_valid && status == ST_WAITING,
               msg_count == '0 && !res.took)

endmodule

### rtl/mqw_store.sv
// Message ring storage: one write port, one registered read port.
module mqw_store
  import mqw_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_idx,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_idx,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

### rtl/mqw_ctrl.sv
// Queue control: ring pointers, count, waiter mask and result register.
module mqw_ctrl
  import mqw_pkg::*;
#(
  parameter int DEPTH     = 16,
  parameter int MAX_TASKS = 16,
  parameter int AW        = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [2:0]        req_type,
  input  logic [7:0]        msg_in,
  input  logic [TASK_W-1:0] task_id,
  input  logic              cfg_wr_en,
  input  logic [CAP_W-1:0]  cfg_wr_data,
  output logic              mem_wr_en,
  output logic [AW-1:0]     mem_wr_idx,
  output logic [7:0]        mem_wr_data,
  output logic              mem_rd_en,
  output logic [AW-1:0]     mem_rd_idx,
  output mqw_res_t          res
);

  localparam int PW = (AW > CAP_W) ? AW : CAP_W;

  logic [CAP_W-1:0]     capacity;
  logic [PW-1:0]        read_slot, read_slot_next;
  logic [CAP_W-1:0]     held, held_next;
  logic [MAX_TASKS-1:0] waiters, waiters_next;

  logic [CAP_W-1:0]     cap;
  logic [PW:0]          cap_p, tail_sum, inc_sum;
  logic [PW-1:0]        tail_slot, front_slot, take_slot;
  logic [MAX_TASKS-1:0] task_bit;
  logic [TASK_W-1:0]    low_idx;
  logic                 posting;
  mqw_res_t             res_next;

  // clamp capacity into 1..DEPTH
  always_comb begin
    if (capacity == '0) begin
      cap = CAP_W'(1);
    end else if ({4'd0, capacity} > 9'(DEPTH)) begin
      cap = CAP_W'(DEPTH);
    end else begin
      cap = capacity;
    end
  end

  assign cap_p    = (PW+1)'(cap);
  assign tail_sum = {1'b0, read_slot} + (PW+1)'(held);
  assign inc_sum  = {1'b0, read_slot} + (PW+1)'(1);
  assign tail_slot  = (tail_sum >= cap_p) ? PW'(tail_sum - cap_p) : tail_sum[PW-1:0];
  assign front_slot = (read_slot == '0) ? PW'(cap) - PW'(1) : read_slot - PW'(1);
  assign take_slot  = (inc_sum >= cap_p) ? '0 : inc_sum[PW-1:0];

  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      task_bit[i] = (task_id == TASK_W'(i));
    end
  end

  // lowest waiting task
  always_comb begin
    low_idx = '0;
    for (int i = MAX_TASKS - 1; i >= 0; i--) begin
      if (waiters[i]) begin
        low_idx = TASK_W'(i);
      end
    end
  end

  assign posting = (req_type == REQ_POST_BACK) || (req_type == REQ_POST_FRONT);

  always_comb begin
    read_slot_next      = read_slot;
    held_next           = held;
    waiters_next        = waiters;
    res_next.status     = ST_OK;
    res_next.took       = 1'b0;
    res_next.wake_valid = 1'b0;
    res_next.wake_task  = '0;
    mem_wr_en           = 1'b0;
    mem_wr_idx          = tail_slot[AW-1:0];
    mem_wr_data         = msg_in;
    mem_rd_idx          = read_slot[AW-1:0];
    unique case (req_type)
      REQ_POST_BACK, REQ_POST_FRONT: begin
        if (held >= cap) begin
          res_next.status = ST_FULL;
        end else begin
          mem_wr_en = 1'b1;
          if (req_type == REQ_POST_FRONT) begin
            read_slot_next = front_slot;
            mem_wr_idx     = front_slot[AW-1:0];
          end
          held_next = held + CAP_W'(1);
          if (held == '0 && waiters != '0) begin
            res_next.wake_valid = 1'b1;
            res_next.wake_task  = low_idx;
            waiters_next = waiters & ~(MAX_TASKS'(1) << low_idx);
          end
        end
      end
      REQ_ACCEPT: begin
        if (held == '0) begin
          res_next.status = ST_EMPTY;
        end else begin
          res_next.took  = 1'b1;
          read_slot_next = take_slot;
          held_next      = held - CAP_W'(1);
        end
      end
      REQ_PEND: begin
        if (held == '0) begin
          waiters_next    = waiters | task_bit;
          res_next.status = ST_WAITING;
        end else begin
          waiters_next   = waiters & ~task_bit;
          res_next.took  = 1'b1;
          read_slot_next = take_slot;
          held_next      = held - CAP_W'(1);
        end
      end
      REQ_TIMEOUT: begin
        waiters_next = waiters & ~task_bit;
        if (held == '0) begin
          res_next.status = ST_TIMEOUT;
        end else begin
          res_next.took  = 1'b1;
          read_slot_next = take_slot;
          held_next      = held - CAP_W'(1);
        end
      end
      REQ_FLUSH: begin
        held_next      = '0;
        read_slot_next = '0;
      end
      default: begin
      end
    endcase
    res_next.msg_count  = held_next;
    res_next.slot_count = cap;
    mem_wr_en = mem_wr_en & accept & posting;
    mem_rd_en = accept & res_next.took;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      read_slot <= '0;
      held      <= '0;
      waiters   <= '0;
    end else if (cfg_wr_en) begin
      capacity  <= cfg_wr_data;
      read_slot <= '0;
      held      <= '0;
      waiters   <= '0;
    end else if (accept) begin
      read_slot <= read_slot_next;
      held      <= held_next;
      waiters   <= waiters_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

endmodule

### tb/testbench.sv
// Testbench for the message queue core: directed and random request traffic.
module testbench;
  import mqw_pkg::*;

  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam int RING_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        msg;
    logic              wake_valid;
    logic [TASK_W-1:0] wake_task;
    logic [CAP_W-1:0]  msg_count;
    logic [CAP_W-1:0]  slot_count;
  } queue_reply_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [2:0]        req_type;
  logic [7:0]        msg_in;
  logic [TASK_W-1:0] task_id;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        status;
  logic [7:0]        msg_out;
  logic              wake_valid;
  logic [TASK_W-1:0] wake_task;
  logic [CAP_W-1:0]  msg_count;
  logic [CAP_W-1:0]  slot_count;
  logic              cfg_wr_en;
  logic [CAP_W-1:0]  cfg_wr_data;

  // predictor state
  logic [7:0]       ring [RING_DEPTH];
  int               head_slot;
  int               held;
  logic [15:0]      waiters;
  logic [CAP_W-1:0] capacity_reg;

  queue_reply_t pending_replies[$];

  int idle_pct;
  int stall_pct;
  int mismatches;
  int cycle_count;
  int requests_sent;
  int replies_seen;
  int wakes_seen;
  int full_seen;
  int cap_writes;

  message_queue_with_waiters_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .msg_in     (msg_in),
    .task_id    (task_id),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .msg_out    (msg_out),
    .wake_valid (wake_valid),
    .wake_task  (wake_task),
    .msg_count  (msg_count),
    .slot_count (slot_count),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic int active_slots();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > RING_DEPTH) return RING_DEPTH;
    return capacity_reg;
  endfunction

  function automatic logic [7:0] take_oldest(int cap);
    logic [7:0] v;
    v = ring[head_slot];
    head_slot = (head_slot + 1 >= cap) ? 0 : head_slot + 1;
    held--;
    return v;
  endfunction

  // Advances the predictor by one request and returns the reply it should give.
  function automatic queue_reply_t apply_queue_request(logic [2:0] kind, logic [7:0] data,
                                                       logic [TASK_W-1:0] tid);
    queue_reply_t r;
    int cap;
    int pos;
    cap = active_slots();
    r = '0;
    r.status = ST_OK;
    case (kind)
      REQ_POST_BACK, REQ_POST_FRONT: begin
        if (held >= cap) begin
          r.status = ST_FULL;
        end else begin
          if (kind == REQ_POST_BACK) begin
            pos = head_slot + held;
            if (pos >= cap) pos -= cap;
            ring[pos] = data;
          end else begin
            head_slot = (head_slot == 0) ? cap - 1 : head_slot - 1;
            ring[head_slot] = data;
          end
          held++;
          // first message wakes the lowest waiting task
          if (held == 1) begin
            for (int i = 0; i < 16 && !r.wake_valid; i++) begin
              if (waiters[i]) begin
                waiters[i] = 1'b0;
                r.wake_valid = 1'b1;
                r.wake_task = TASK_W'(i);
              end
            end
          end
        end
      end
      REQ_ACCEPT: begin
        if (held == 0) r.status = ST_EMPTY;
        else r.msg = take_oldest(cap);
      end
      REQ_PEND: begin
        if (held == 0) begin
          waiters[tid] = 1'b1;
          r.status = ST_WAITING;
        end else begin
          waiters[tid] = 1'b0;
          r.msg = take_oldest(cap);
        end
      end
      REQ_TIMEOUT: begin
        waiters[tid] = 1'b0;
        if (held == 0) r.status = ST_TIMEOUT;
        else r.msg = take_oldest(cap);
      end
      REQ_FLUSH: begin
        held = 0;
        head_slot = 0;
      end
      default: begin
      end
    endcase
    r.msg_count = CAP_W'(held);
    r.slot_count = CAP_W'(cap);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 30)
      $display("MISMATCH t=%0t %s: got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk) begin
    queue_reply_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_replies.size() == 0) begin
        report_mismatch("reply with no request outstanding", status, 0);
      end else begin
        want = pending_replies.pop_front();
        replies_seen++;
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (msg_out !== want.msg) report_mismatch("msg_out", msg_out, want.msg);
        if (wake_valid !== want.wake_valid)
          report_mismatch("wake_valid", wake_valid, want.wake_valid);
        if (wake_task !== want.wake_task)
          report_mismatch("wake_task", wake_task, want.wake_task);
        if (msg_count !== want.msg_count)
          report_mismatch("msg_count", msg_count, want.msg_count);
        if (slot_count !== want.slot_count)
          report_mismatch("slot_count", slot_count, want.slot_count);
      end
    end
  end

  // Drives one request; returns at the edge where it was taken.
  task automatic send_request(input logic [2:0] kind, input logic [7:0] data,
                              input logic [TASK_W-1:0] tid);
    queue_reply_t r;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    msg_in   <= data;
    task_id  <= tid;
    do @(posedge clk); while (in_stall);
    r = apply_queue_request(kind, data, tid);
    pending_replies.push_back(r);
    requests_sent++;
    if (r.wake_valid) wakes_seen++;
    if (r.status == ST_FULL) full_seen++;
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_replies();
    go_quiet();
    wait (pending_replies.size() == 0);
    repeat (3) @(posedge clk);
  endtask

  // A capacity write empties the queue, so only do it with nothing in flight.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain_replies();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    capacity_reg = value;
    head_slot = 0;
    held = 0;
    waiters = '0;
    cap_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [2:0] pick_request(int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      0: begin
        if (r < 40) return REQ_POST_BACK;
        if (r < 70) return REQ_POST_FRONT;
        if (r < 78) return REQ_ACCEPT;
        if (r < 88) return REQ_PEND;
        if (r < 95) return REQ_TIMEOUT;
        if (r < 98) return REQ_FLUSH;
      end
      1: begin
        if (r < 15) return REQ_POST_BACK;
        if (r < 25) return REQ_POST_FRONT;
        if (r < 50) return REQ_ACCEPT;
        if (r < 75) return REQ_PEND;
        if (r < 92) return REQ_TIMEOUT;
        if (r < 96) return REQ_FLUSH;
      end
      default: begin
        if (r < 25) return REQ_POST_BACK;
        if (r < 45) return REQ_POST_FRONT;
        if (r < 60) return REQ_ACCEPT;
        if (r < 75) return REQ_PEND;
        if (r < 88) return REQ_TIMEOUT;
        if (r < 94) return REQ_FLUSH;
      end
    endcase
    return $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
  endfunction

  // Every request kind at reset capacity, including wakeups and unused codes.
  task automatic test_request_kinds();
    send_request(REQ_ACCEPT, 8'h00, 4'd0);      // empty
    send_request(REQ_TIMEOUT, 8'h00, 4'd0);     // timeout, nothing queued
    send_request(REQ_PEND, 8'h00, 4'd15);       // waiting
    send_request(REQ_PEND, 8'h00, 4'd3);
    send_request(REQ_PEND, 8'h00, 4'd0);
    send_request(REQ_POST_BACK, 8'hFF, 4'd0);   // wakes task 0
    send_request(REQ_POST_FRONT, 8'h00, 4'd0);  // count 2, no wake
    send_request(REQ_ACCEPT, 8'h00, 4'd0);
    send_request(REQ_PEND, 8'h00, 4'd3);        // takes and clears mark of 3
    send_request(REQ_POST_BACK, 8'hA5, 4'd0);   // wakes task 15
    send_request(REQ_TIMEOUT, 8'h00, 4'd15);    // message present
    send_request(REQ_SPARE_LO, 8'h3C, 4'd7);
    send_request(REQ_SPARE_HI, 8'hC3, 4'd8);
    send_request(REQ_POST_FRONT, 8'h5A, 4'd0);
    send_request(REQ_FLUSH, 8'h00, 4'd0);
  endtask

  // Clamped capacities, full queue, and waiters cleared by a capacity write.
  task automatic test_capacity_limits();
    write_capacity(5'd0);                       // acts as one slot
    send_request(REQ_POST_BACK, 8'h5A, 4'd0);
    send_request(REQ_POST_BACK, 8'h11, 4'd0);   // full
    send_request(REQ_POST_FRONT, 8'h22, 4'd0);  // full
    send_request(REQ_ACCEPT, 8'h00, 4'd0);
    send_request(REQ_POST_FRONT, 8'h81, 4'd0);
    send_request(REQ_FLUSH, 8'h00, 4'd0);
    write_capacity(5'd31);                      // acts as the full ring
    send_request(REQ_PEND, 8'h00, 4'd9);
    write_capacity(5'd2);
    send_request(REQ_POST_BACK, 8'h7E, 4'd0);   // mark of 9 is gone
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int count,
                                     input logic [CAP_W-1:0] first_cap);
    int mode;
    logic [CAP_W-1:0] cap;
    drain_replies();
    idle_pct = idle;
    stall_pct = stall;
    for (int n = 0; n < count; n += 30) begin
      if (n == 0) cap = first_cap;
      else if ($urandom_range(2) == 0) cap = CAP_W'($urandom_range(31));
      else cap = CAP_W'($urandom_range(1, 4));
      write_capacity(cap);
      mode = $urandom_range(2);
      for (int k = 0; k < 30; k++) begin
        send_request(pick_request(mode), 8'($urandom_range(255)),
                     TASK_W'($urandom_range(15)));
        if (k % 10 == 9) mode = $urandom_range(2);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_POST_BACK;
    msg_in = '0;
    task_id = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    idle_pct = 0;
    stall_pct = 0;
    mismatches = 0;
    requests_sent = 0;
    replies_seen = 0;
    wakes_seen = 0;
    full_seen = 0;
    cap_writes = 0;
    head_slot = 0;
    held = 0;
    waiters = '0;
    capacity_reg = CAP_RESET;
    for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_request_kinds();
    test_capacity_limits();
    test_random_traffic(0, 0, 150, 5'd16);
    test_random_traffic(47, 0, 150, 5'd1);
    test_random_traffic(0, 47, 150, 5'd31);
    test_random_traffic(37, 37, 150, 5'd3);

    drain_replies();
    repeat (5) @(posedge clk);
    $display("covered %0d requests, %0d replies checked, %0d capacity writes",
             requests_sent, replies_seen, cap_writes);
    $display("saw %0d task wakeups and %0d full rejections over four idle/stall mixes",
             wakes_seen, full_seen);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
             pending_replies.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/mqw_pkg.sv
rtl/mqw_store.sv
rtl/mqw_ctrl.sv
rtl/message_queue_with_waiters_core.sv
tb/testbench.sv
